[rtl/nnis_pkg.sv]
package nnis_pkg;

   localparam int COORD_BITS  = 12;
   localparam int SIZE_BITS   = 13;
   localparam int SRC_BITS    = 9;
   localparam int STEP_BITS   = 25;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_BITS   = COORD_BITS + STEP_BITS;
   localparam int SCALED_BITS = PROD_BITS - FRAC_BITS;
   localparam int CCOUNT_BITS = 3;
   localparam int CHAN_BITS   = 8;
   localparam int NUM_CHANS   = 4;
   localparam int LIN_BITS    = 2 * COORD_BITS;
   localparam int CSR_IDX_BITS = 3;

   // Request kinds carried on tuser.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEST_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEST_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_X_STEP        = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_Y_STEP        = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd6;

   typedef logic [NUM_CHANS-1:0][CHAN_BITS-1:0] samples_type;

endpackage

[rtl/nearest_neighbor_image_scaler_unit.sv]
// Nearest-neighbor scaler over an on-chip source frame store. A write request (tuser 0)
// stores one pixel at source column/row; writes outside the configured source size are
// dropped without a response. A read request (tuser 1) names a destination pixel, which is
// mapped to source column (x * x_step) >> 16 and row (y * y_step) >> 16, clamped to the
// source size, and answered with the stored pixel; reads beyond the destination size
// answer zeros with tuser set. One request is taken every clock while the skid stage is
// empty, set by the single port of the frame store, which serves one write or one read
// per cycle. A read response passes the pipeline stages and the frame store read into the
// output register; it and a skid stage keep the request side open while one response waits.
// The frame store has no reset and needs no clearing pass: a pixel must be written before it
// is read. The user must write configuration while no request is in flight; the block does not enforce it.
module nearest_neighbor_image_scaler_unit
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int SAMPLE_BITS  = 8,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // coord_x, coord_y, in_chan0, in_chan1, in_chan2, in_chan3
   input  logic [55:0]             req_tdata,
   // func
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_chan0, out_chan1, out_chan2, out_chan3
   output logic [31:0]             rsp_tdata,
   // out_of_range
   output logic                    rsp_tuser,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [STEP_BITS-1:0]    csr_data
);

   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_BITS = MAX_CHANNELS * SAMPLE_BITS;
   localparam logic [SIZE_BITS-1:0] MAX_W = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] MAX_H = SIZE_BITS'(MAX_HEIGHT);
   localparam logic [LIN_BITS-1:0]  ROW_PITCH = LIN_BITS'(MAX_WIDTH);

   // Configuration registers.
   logic [SRC_BITS-1:0]    source_width_ff, source_height_ff;
   logic [SIZE_BITS-1:0]   dest_width_ff, dest_height_ff;
   logic [STEP_BITS-1:0]   x_step_ff, y_step_ff;
   logic [CCOUNT_BITS-1:0] channel_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= SRC_BITS'(256);
         source_height_ff <= SRC_BITS'(256);
         dest_width_ff    <= SIZE_BITS'(256);
         dest_height_ff   <= SIZE_BITS'(256);
         x_step_ff        <= STEP_BITS'(65536);
         y_step_ff        <= STEP_BITS'(65536);
         channel_count_ff <= CCOUNT_BITS'(3);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  source_width_ff  <= csr_data[SRC_BITS-1:0];
            REG_SOURCE_HEIGHT: source_height_ff <= csr_data[SRC_BITS-1:0];
            REG_DEST_WIDTH:    dest_width_ff    <= csr_data[SIZE_BITS-1:0];
            REG_DEST_HEIGHT:   dest_height_ff   <= csr_data[SIZE_BITS-1:0];
            REG_X_STEP:        x_step_ff        <= csr_data;
            REG_Y_STEP:        y_step_ff        <= csr_data;
            REG_CHANNEL_COUNT: channel_count_ff <= csr_data[CCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Source size saturated into one..maximum.
   logic [SIZE_BITS-1:0] src_w, src_h;

   always_comb begin
      if (source_width_ff == '0) begin
         src_w = SIZE_BITS'(1);
      end else if (SIZE_BITS'(source_width_ff) > MAX_W) begin
         src_w = MAX_W;
      end else begin
         src_w = SIZE_BITS'(source_width_ff);
      end
      if (source_height_ff == '0) begin
         src_h = SIZE_BITS'(1);
      end else if (SIZE_BITS'(source_height_ff) > MAX_H) begin
         src_h = MAX_H;
      end else begin
         src_h = SIZE_BITS'(source_height_ff);
      end
   end

   // The whole pipeline stalls only while the skid stage holds a response.
   logic skid_valid_ff;
   logic pipe_en;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   // Stage 1: captured request.
   logic                   s1_valid_ff, s1_func_ff;
   logic [COORD_BITS-1:0]  s1_cx_ff, s1_cy_ff;
   samples_type            s1_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_func_ff <= req_tuser;
         s1_cx_ff   <= req_tdata[11:0];
         s1_cy_ff   <= req_tdata[23:12];
         s1_chan_ff <= req_tdata[55:24];
      end
   end

   // Stage 1 work: scale products and range checks.
   logic [PROD_BITS-1:0] prod_x_in, prod_y_in;
   logic                 oor_in, wr_ok_in;

   assign prod_x_in = PROD_BITS'(s1_cx_ff) * PROD_BITS'(x_step_ff);
   assign prod_y_in = PROD_BITS'(s1_cy_ff) * PROD_BITS'(y_step_ff);
   assign oor_in    = (SIZE_BITS'(s1_cx_ff) >= dest_width_ff) ||
                      (SIZE_BITS'(s1_cy_ff) >= dest_height_ff);
   assign wr_ok_in  = (SIZE_BITS'(s1_cx_ff) < src_w) && (SIZE_BITS'(s1_cy_ff) < src_h);

   // Stage 2: scaled coordinates, then the frame store access.
   logic                   s2_valid_ff, s2_func_ff, s2_oor_ff, s2_wr_ok_ff;
   logic [SCALED_BITS-1:0] s2_sx_ff, s2_sy_ff;
   logic [COORD_BITS-1:0]  s2_cx_ff, s2_cy_ff;
   samples_type            s2_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_func_ff  <= s1_func_ff;
         s2_oor_ff   <= oor_in;
         s2_wr_ok_ff <= wr_ok_in;
         s2_sx_ff    <= prod_x_in[PROD_BITS-1:FRAC_BITS];
         s2_sy_ff    <= prod_y_in[PROD_BITS-1:FRAC_BITS];
         s2_cx_ff    <= s1_cx_ff;
         s2_cy_ff    <= s1_cy_ff;
         s2_chan_ff  <= s1_chan_ff;
      end
   end

   logic [SIZE_BITS-1:0] col, row;
   logic [LIN_BITS-1:0]  rd_lin, wr_lin;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [WORD_BITS-1:0] wr_word;
   logic                 mem_we, mem_re;

   assign col = (s2_sx_ff >= SCALED_BITS'(src_w)) ? src_w - SIZE_BITS'(1)
                                                  : s2_sx_ff[SIZE_BITS-1:0];
   assign row = (s2_sy_ff >= SCALED_BITS'(src_h)) ? src_h - SIZE_BITS'(1)
                                                  : s2_sy_ff[SIZE_BITS-1:0];
   assign rd_lin = LIN_BITS'(row) * ROW_PITCH + LIN_BITS'(col);
   assign wr_lin = LIN_BITS'(s2_cy_ff) * ROW_PITCH + LIN_BITS'(s2_cx_ff);
   assign mem_addr = (s2_func_ff == FUNC_READ) ? rd_lin[ADDR_BITS-1:0]
                                               : wr_lin[ADDR_BITS-1:0];
   assign mem_we = pipe_en && s2_valid_ff && (s2_func_ff == FUNC_WRITE) && s2_wr_ok_ff;
   assign mem_re = pipe_en && s2_valid_ff && (s2_func_ff == FUNC_READ);

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_wr
      logic [15:0] sample_ext;
      assign sample_ext = 16'(s2_chan_ff[c]);
      assign wr_word[c*SAMPLE_BITS +: SAMPLE_BITS] = sample_ext[SAMPLE_BITS-1:0];
   end

   // Frame store: one port, one access per cycle, registered read data.
   logic [WORD_BITS-1:0] frame_mem [DEPTH];
   logic [WORD_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= wr_word;
      end
      if (mem_re) begin
         rd_word_ff <= frame_mem[mem_addr];
      end
   end

   // Stage 3: read data available, response formed.
   logic s3_valid_ff, s3_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= s2_valid_ff && (s2_func_ff == FUNC_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_oor_ff <= s2_oor_ff;
      end
   end

   samples_type res_chan;

   for (genvar c = 0; c < NUM_CHANS; c++) begin : g_rd
      if (c < MAX_CHANNELS) begin : g_used
         logic [15:0] sample_ext;
         assign sample_ext  = 16'(rd_word_ff[c*SAMPLE_BITS +: SAMPLE_BITS]);
         assign res_chan[c] = (!s3_oor_ff && (CCOUNT_BITS'(c) < channel_count_ff))
                              ? sample_ext[CHAN_BITS-1:0] : '0;
      end else begin : g_unused
         assign res_chan[c] = '0;
      end
   end

   // Output register with a skid stage behind it.
   logic        produced;
   logic        rsp_valid_ff, rsp_oor_ff, skid_oor_ff;
   samples_type rsp_chan_ff, skid_chan_ff;

   assign produced = s3_valid_ff && pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= produced;
         end
      end else if (produced) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_chan_ff <= skid_chan_ff;
            rsp_oor_ff  <= skid_oor_ff;
         end else begin
            rsp_chan_ff <= res_chan;
            rsp_oor_ff  <= s3_oor_ff;
         end
      end else if (produced) begin
         skid_chan_ff <= res_chan;
         skid_oor_ff  <= s3_oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_chan_ff;
   assign rsp_tuser  = rsp_oor_ff;

endmodule
